// File: rtl/scancode_set1_keysym_decoder_top_assert.svh
// Assertion macros used by the decode stage RTL.
`ifndef SCANCODE_SET1_KEYSYM_DECODER_TOP_ASSERT_SVH
`define SCANCODE_SET1_KEYSYM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SC1KD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("sc1kd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SC1KD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("sc1kd: next-cycle check failed");

`endif

// File: rtl/sc1kd_pkg.sv
package sc1kd_pkg;

    localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
    localparam logic [6:0] FAKE_SHIFT_L = 7'h2A;
    localparam logic [6:0] FAKE_SHIFT_R = 7'h36;
    localparam logic [6:0] EXT_BASE     = 7'h60;
    localparam logic [6:0] EXT_LAST     = 7'h76;

    localparam logic [2:0] ST_KEY       = 3'd0;
    localparam logic [2:0] ST_PREFIX    = 3'd1;
    localparam logic [2:0] ST_FAKESHIFT = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // Registered input word handed to the decode stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] code_byte;
    } in_word_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] keysym;
    } ext_hit_t;

    // Fixed extended-code table.
    function automatic ext_hit_t ext_lookup(input logic [6:0] code);
        ext_hit_t r;
        r.hit = 1'b1;
        unique case (code)
            7'h1C:   r.keysym = EXT_BASE + 7'd0;
            7'h1D:   r.keysym = EXT_BASE + 7'd1;
            7'h35:   r.keysym = EXT_BASE + 7'd2;
            7'h37:   r.keysym = EXT_BASE + 7'd3;
            7'h38:   r.keysym = EXT_BASE + 7'd4;
            7'h46:   r.keysym = EXT_BASE + 7'd5;
            7'h47:   r.keysym = EXT_BASE + 7'd6;
            7'h48:   r.keysym = EXT_BASE + 7'd7;
            7'h49:   r.keysym = EXT_BASE + 7'd8;
            7'h4B:   r.keysym = EXT_BASE + 7'd9;
            7'h4D:   r.keysym = EXT_BASE + 7'd10;
            7'h4F:   r.keysym = EXT_BASE + 7'd11;
            7'h50:   r.keysym = EXT_BASE + 7'd12;
            7'h51:   r.keysym = EXT_BASE + 7'd13;
            7'h52:   r.keysym = EXT_BASE + 7'd14;
            7'h53:   r.keysym = EXT_BASE + 7'd15;
            7'h6F:   r.keysym = EXT_BASE + 7'd16;
            7'h3D:   r.keysym = EXT_BASE + 7'd17;
            7'h3E:   r.keysym = EXT_BASE + 7'd18;
            7'h3F:   r.keysym = EXT_BASE + 7'd19;
            7'h40:   r.keysym = EXT_BASE + 7'd20;
            7'h41:   r.keysym = EXT_BASE + 7'd21;
            7'h4E:   r.keysym = EXT_BASE + 7'd22;
            default:
            begin
                r.hit    = 1'b0;
                r.keysym = 7'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/sc1kd_in_reg.sv
module sc1kd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          code_byte,
    output sc1kd_pkg::in_word_t stage,
    input  logic                stage_ready
);
    import sc1kd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       in_fire;

    assign in_ready   = !valid_reg || stage_ready;
    assign in_fire    = in_valid && in_ready;
    assign valid_next = in_fire || (valid_reg && !stage_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= code_byte;
        end
    end

    assign stage.valid     = valid_reg;
    assign stage.code_byte = byte_reg;

endmodule

// File: rtl/sc1kd_dec_stage.sv
module sc1kd_dec_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  sc1kd_pkg::in_word_t stage,
    output logic                stage_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          keysym,
    output logic                released,
    output logic [2:0]          status
);
    import sc1kd_pkg::*;

    logic       ext_pending_reg, ext_pending_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] keysym_reg, keysym_next;
    logic       released_reg, released_next;
    logic [2:0] status_reg, status_next;
    logic       fire;
    logic [6:0] code;
    logic       rel;
    ext_hit_t   ext;

    assign stage_ready = !out_valid_reg || out_ready;
    assign fire        = stage.valid && stage_ready;
    assign code        = stage.code_byte[6:0];
    assign rel         = stage.code_byte[7];
    assign ext         = ext_lookup(code);

    always_comb
    begin
        keysym_next      = 7'd0;
        released_next    = 1'b0;
        status_next      = ST_KEY;
        ext_pending_next = 1'b0;
        if (stage.code_byte == PREFIX_BYTE)
        begin
            ext_pending_next = 1'b1;
            status_next      = ST_PREFIX;
        end
        else if (ext_pending_reg)
        begin
            if (code == FAKE_SHIFT_L || code == FAKE_SHIFT_R)
            begin
                status_next = ST_FAKESHIFT;
            end
            else if (!ext.hit)
            begin
                status_next = ST_UNKNOWN;
            end
            else
            begin
                keysym_next   = ext.keysym;
                released_next = rel;
            end
        end
        else if (code >= EXT_BASE)
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            keysym_next   = code;
            released_next = rel;
        end
    end

    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            ext_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                ext_pending_reg <= ext_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            keysym_reg   <= keysym_next;
            released_reg <= released_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign keysym    = keysym_reg;
    assign released  = released_reg;
    assign status    = status_reg;

    `include "scancode_set1_keysym_decoder_top_assert.svh"

    // only key events carry a keysym or a release bit
    `SC1KD_ASSERT_IMP(a_quiet_non_key, clk, rst_n,
        out_valid_reg && status_reg != ST_KEY, keysym_reg == 7'd0 && !released_reg)
    // a prefix word leaves the flag set
    `SC1KD_ASSERT_NXT(a_prefix_sets, clk, rst_n,
        fire && stage.code_byte == PREFIX_BYTE, ext_pending_reg)
    // any other word clears it
    `SC1KD_ASSERT_NXT(a_other_clears, clk, rst_n,
        fire && stage.code_byte != PREFIX_BYTE, !ext_pending_reg)
    // extended keysyms stay inside the table range
    `SC1KD_ASSERT_IMP(a_ext_range, clk, rst_n,
        out_valid_reg && status_reg == ST_KEY && keysym_reg >= EXT_BASE,
        keysym_reg <= EXT_LAST)

endmodule

// File: rtl/scancode_set1_keysym_decoder_top.sv
// Scan code set 1 decoder.
// Input channel: in_valid / in_ready with one raw keyboard byte per word on
// code_byte. Output channel: out_valid / out_ready with keysym, released and
// status for every input word, in order, one result word per input word.
// A 0xE0 byte latches the extended flag and reports "prefix"; the next byte
// is decoded through the extended table (fake shifts ignored, unmapped codes
// reported unknown) and clears the flag.
// After input accept, the byte is held in the input register, then decoded
// into the result register, which raises out_valid.
// Throughput: one word per cycle unless out_ready stalls; the decode is a
// single table lookup between the input and result registers, and the flag
// update sits in the same stage, so consecutive bytes need no spacing.
// Reset (rst_n low, asynchronous): both stages empty, extended flag cleared.
// When the receiver stalls, the result register holds; the input register
// still takes one more word, after which in_ready drops until out_ready.
module scancode_set1_keysym_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] code_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] keysym,
    output logic       released,
    output logic [2:0] status
);
    import sc1kd_pkg::*;

    // registered input word and its backpressure
    in_word_t stage;
    logic     stage_ready;

    sc1kd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .code_byte   (code_byte),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    // prefix flag, table decode and result register
    sc1kd_dec_stage u_dec_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .stage_ready (stage_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .keysym      (keysym),
        .released    (released),
        .status      (status)
    );

endmodule
